### rtl/dltq_pkg.sv
// Shared types and constants for the doubly linked thread queue.
package dltq_pkg;

    localparam int SLOTS   = 16;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int COUNT_W = $clog2(SLOTS + 1);

    localparam int SLOT_FIELD_W  = 4;
    localparam int COUNT_FIELD_W = 5;

    localparam logic [1:0] KIND_PUSH   = 2'd0;
    localparam logic [1:0] KIND_POP    = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;
    localparam logic [1:0] KIND_NOP    = 2'd3;

    typedef struct packed {
        logic [1:0]              kind;
        logic [SLOT_FIELD_W-1:0] thread_slot;
    } t_in;

    typedef struct packed {
        logic [SLOT_FIELD_W-1:0]  popped_slot;
        logic                     popped_valid;
        logic [COUNT_FIELD_W-1:0] queued_count;
        logic                     is_empty;
        logic                     op_error;
    } t_out;

    typedef struct packed {
        logic capture;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

endpackage

### rtl/dltq_ram.sv
// Generic single write port RAM with registered read.
module dltq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/dltq_ctrl.sv
// Controller: accept an operation, then commit it once the output register is free.
module dltq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  dltq_pkg::t_sts i_sts,
    output dltq_pkg::t_cmd o_cmd
);
    import dltq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/dltq_dp.sv
// Datapath: link memories, head, tail, count, membership bits and output register.
module dltq_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dltq_pkg::t_in   i_in,
    input  dltq_pkg::t_cmd  i_cmd,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output dltq_pkg::t_out  o_out,
    output dltq_pkg::t_sts  o_sts
);
    import dltq_pkg::*;

    logic [1:0]         r_kind, n_kind;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic               r_slot_ok, n_slot_ok;
    logic [SLOT_W-1:0]  r_head, n_head;
    logic [SLOT_W-1:0]  r_tail, n_tail;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [SLOTS-1:0]   r_inq, n_inq;
    t_out               r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic              nx_we, pv_we;
    logic [SLOT_W-1:0] nx_waddr, pv_waddr;
    logic [SLOT_W-1:0] nx_wdata, pv_wdata;
    logic [SLOT_W-1:0] nx_rdata, pv_rdata;
    logic [SLOT_W-1:0] rd_addr;

    logic [SLOT_W-1:0] tgt;
    logic              has_p, has_n;
    logic              do_push, do_unlink, err, popv;

    assign rd_addr = (i_in.kind == KIND_POP) ? r_head : SLOT_W'(i_in.thread_slot);

    dltq_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (nx_we),
        .i_waddr (nx_waddr),
        .i_wdata (nx_wdata),
        .i_re    (i_cmd.capture),
        .i_raddr (rd_addr),
        .o_rdata (nx_rdata)
    );

    dltq_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (pv_we),
        .i_waddr (pv_waddr),
        .i_wdata (pv_wdata),
        .i_re    (i_cmd.capture),
        .i_raddr (rd_addr),
        .o_rdata (pv_rdata)
    );

    always_comb begin
        tgt       = (r_kind == KIND_POP) ? r_head : r_slot;
        has_p     = (tgt != r_head);
        has_n     = (tgt != r_tail);
        do_push   = 1'b0;
        do_unlink = 1'b0;
        err       = 1'b0;
        popv      = 1'b0;
        unique case (r_kind)
            KIND_PUSH: begin
                do_push = r_slot_ok && !r_inq[r_slot];
                err     = !do_push;
            end
            KIND_POP: begin
                do_unlink = (r_count != '0);
                popv      = do_unlink;
            end
            KIND_REMOVE: begin
                do_unlink = r_slot_ok && r_inq[r_slot];
                err       = !do_unlink;
            end
            KIND_NOP: begin
                err = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_kind      = r_kind;
        n_slot      = r_slot;
        n_slot_ok   = r_slot_ok;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_inq       = r_inq;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        nx_we       = 1'b0;
        nx_waddr    = r_tail;
        nx_wdata    = r_slot;
        pv_we       = 1'b0;
        pv_waddr    = r_slot;
        pv_wdata    = r_tail;

        if (i_cmd.capture) begin
            n_kind    = i_in.kind;
            n_slot    = SLOT_W'(i_in.thread_slot);
            n_slot_ok = (int'(i_in.thread_slot) < SLOTS);
        end

        if (i_cmd.commit) begin
            if (do_push) begin
                nx_we    = (r_count != '0);
                pv_we    = 1'b1;
                n_tail   = r_slot;
                if (r_count == '0) begin
                    n_head = r_slot;
                end
                n_inq[r_slot] = 1'b1;
                n_count       = COUNT_W'(r_count + 1'b1);
            end
            if (do_unlink) begin
                if (has_p) begin
                    nx_we    = 1'b1;
                    nx_waddr = pv_rdata;
                    nx_wdata = nx_rdata;
                end else begin
                    n_head = nx_rdata;
                end
                if (has_n) begin
                    pv_we    = 1'b1;
                    pv_waddr = nx_rdata;
                    pv_wdata = pv_rdata;
                end else begin
                    n_tail = pv_rdata;
                end
                n_inq[tgt] = 1'b0;
                n_count    = COUNT_W'(r_count - 1'b1);
            end
            n_out.popped_slot  = popv ? SLOT_FIELD_W'(tgt) : '0;
            n_out.popped_valid = popv;
            n_out.queued_count = COUNT_FIELD_W'(n_count);
            n_out.is_empty     = (n_count == '0);
            n_out.op_error     = err;
            n_out_valid        = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind      <= KIND_NOP;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_inq       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_kind      <= n_kind;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_inq       <= n_inq;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot    <= n_slot;
        r_slot_ok <= n_slot_ok;
        r_out     <= n_out;
    end

    assign o_out_valid    = r_out_valid;
    assign o_out          = r_out;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

endmodule

### rtl/doubly_linked_thread_queue.sv
// Top level of the doubly linked thread queue: controller, datapath and checks.
// An accepted operation is committed from the execute state into the output register.
// No new operation is accepted until commit: the link memories are read at acceptance
//   and written back at commit; a full, unread output register stalls the commit.
// Reset: synchronous, active low; empties the queue and clears the membership bits.
//   The link memories are not cleared and need no clearing pass.
module doubly_linked_thread_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  dltq_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output dltq_pkg::t_out  o_out
);
    import dltq_pkg::*;

    t_cmd cmd;
    t_sts sts;

    dltq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dltq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .o_sts       (sts)
    );

`ifndef NO_ASSERTIONS
    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |=> o_out_valid)
        else $error("committed beat not presented");

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> (!o_out_valid || i_out_ready))
        else $error("commit overwrote a pending beat");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.is_empty == (o_out.queued_count == '0)))
        else $error("empty flag disagrees with count");

    a_pop_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.popped_valid) |-> (!o_out.op_error && !o_out.is_empty
            || !o_out.op_error))
        else $error("successful pop flagged as error");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (int'(o_out.queued_count) <= SLOTS))
        else $error("count exceeds slot total");
`endif

endmodule
